// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, quiet while reset is applied
`define TCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked property, also live during reset
`define TCW_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

    // Default screen geometry
    localparam int DefColumns = 80;
    localparam int DefRows    = 25;

    // Fixed field widths
    localparam int CellW    = 16;
    localparam int CharW    = 8;
    localparam int AttrW    = 8;
    localparam int KindW    = 2;
    localparam int AddrInW  = 11;
    localparam int RowOutW  = 5;
    localparam int ColOutW  = 7;

    // Item kinds
    localparam logic [KindW-1:0] KindWrite = 2'd0;
    localparam logic [KindW-1:0] KindClear = 2'd1;
    localparam logic [KindW-1:0] KindRead  = 2'd2;

    // Character and cell constants
    localparam logic [CharW-1:0] NewlineCode = 8'd10;
    localparam logic [CharW-1:0] SpaceCode   = 8'h20;
    localparam logic [CellW-1:0] ResetCell   = 16'h0720;
    localparam logic [AttrW-1:0] ResetAttr   = 8'h07;

    typedef struct packed {
        logic [KindW-1:0]   kind;
        logic [CharW-1:0]   char_code;
        logic [AddrInW-1:0] cell_address;
    } t_in_beat;

    typedef struct packed {
        logic [CellW-1:0]   read_data;
        logic [RowOutW-1:0] cursor_row;
        logic [ColOutW-1:0] cursor_column;
    } t_out_beat;

endpackage

// ----- rtl/tcw_ram.sv -----
module tcw_ram #(
    parameter int WIDTH = tcw_pkg::CellW,
    parameter int DEPTH = tcw_pkg::DefColumns * tcw_pkg::DefRows
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tcw_ctrl.sv -----
`include "assert_macros.svh"

module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::DefColumns,
    parameter int ROWS    = tcw_pkg::DefRows
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request side
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  tcw_pkg::t_in_beat                 i_req,
    // result side
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output tcw_pkg::t_out_beat                o_res,
    // current attribute
    input  logic [tcw_pkg::AttrW-1:0]         i_attr,
    // screen memory port
    output logic                              o_mem_we,
    output logic [$clog2(COLUMNS*ROWS)-1:0]   o_mem_waddr,
    output logic [tcw_pkg::CellW-1:0]         o_mem_wdata,
    output logic                              o_mem_re,
    output logic [$clog2(COLUMNS*ROWS)-1:0]   o_mem_raddr,
    input  logic [tcw_pkg::CellW-1:0]         i_mem_rdata
);

    localparam int Cells   = COLUMNS * ROWS;
    localparam int AW      = $clog2(Cells);
    localparam int IW      = $clog2(Cells + 1);
    localparam int RW      = $clog2(ROWS + 1);
    localparam int CW      = $clog2(COLUMNS + 1);
    localparam int RowOutW = tcw_pkg::RowOutW;
    localparam int ColOutW = tcw_pkg::ColOutW;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SCROLL,
        S_PUT,
        S_RESP
    } t_state;

    t_state                    r_state;
    logic [IW-1:0]             r_idx;
    logic [RW-1:0]             r_row;
    logic [CW-1:0]             r_col;
    logic [1:0]                r_scrolls;
    logic                      r_do_put;
    logic                      r_rd_sel;
    logic [AW-1:0]             r_put_addr;
    logic [tcw_pkg::CellW-1:0] r_put_data;
    logic                      r_wr_pend;
    logic                      r_wr_src;
    logic [AW-1:0]             r_wr_addr;

    logic                      accept;
    logic                      addr_ok;
    logic [tcw_pkg::CellW-1:0] blank;
    logic [RW-1:0]             c_row;
    logic [CW-1:0]             c_col;
    logic [CW-1:0]             c_col_next;
    logic [1:0]                c_scrolls;
    logic                      c_is_put;
    logic [AW-1:0]             c_put_addr;

    assign accept  = i_req_valid && o_req_ready;
    assign addr_ok = 32'(i_req.cell_address) < 32'(Cells);
    assign blank   = {i_attr, tcw_pkg::SpaceCode};

    // Cursor step for a character or newline, scroll count up to two
    always_comb begin
        c_row      = r_row;
        c_col      = r_col;
        c_col_next = r_col;
        c_scrolls  = 2'd0;
        c_is_put   = 1'b0;
        if (i_req.char_code == tcw_pkg::NewlineCode) begin
            c_col_next = '0;
            if (r_row == RW'(ROWS)) begin
                c_scrolls = 2'd1;
            end else begin
                c_row = r_row + 1'b1;
            end
        end else begin
            c_is_put = 1'b1;
            if (r_col >= CW'(COLUMNS)) begin
                c_col = '0;
                if (r_row == RW'(ROWS)) begin
                    c_scrolls = 2'd1;
                end else begin
                    c_row = r_row + 1'b1;
                end
            end
            if (c_row == RW'(ROWS)) begin
                c_scrolls = c_scrolls + 2'd1;
                c_row     = RW'(ROWS - 1);
            end
            c_col_next = c_col + 1'b1;
        end
    end

    assign c_put_addr = AW'(AW'(c_row) * AW'(COLUMNS)) + AW'(c_col);

    // Memory port steering per state
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx[AW-1:0];
        o_mem_wdata = blank;
        o_mem_re    = 1'b0;
        o_mem_raddr = AW'(i_req.cell_address);
        unique case (r_state)
            S_INIT: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = tcw_pkg::ResetCell;
            end
            S_CLEAR: begin
                o_mem_we = 1'b1;
            end
            S_IDLE: begin
                if (accept && i_req.kind == tcw_pkg::KindWrite && c_is_put
                        && c_scrolls == 2'd0) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = c_put_addr;
                    o_mem_wdata = {i_attr, i_req.char_code};
                end
                if (accept && i_req.kind == tcw_pkg::KindRead && addr_ok) begin
                    o_mem_re = 1'b1;
                end
            end
            S_SCROLL: begin
                // read one row ahead, write back in the next cycle
                if (r_idx < IW'(Cells - COLUMNS)) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_idx[AW-1:0] + AW'(COLUMNS);
                end
                if (r_wr_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_wr_addr;
                    o_mem_wdata = r_wr_src ? i_mem_rdata : blank;
                end
            end
            S_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_put_addr;
                o_mem_wdata = r_put_data;
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // Sequencer: state, cursor and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_idx     <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_scrolls <= 2'd0;
            r_do_put  <= 1'b0;
            r_rd_sel  <= 1'b0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    if (r_idx == IW'(Cells - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_idx    <= '0;
                        r_rd_sel <= 1'b0;
                        unique case (i_req.kind)
                            tcw_pkg::KindWrite: begin
                                r_row      <= c_row;
                                r_col      <= c_col_next;
                                r_put_addr <= c_put_addr;
                                r_put_data <= {i_attr, i_req.char_code};
                                r_do_put   <= c_is_put;
                                r_scrolls  <= c_scrolls;
                                r_state    <= (c_scrolls != 2'd0) ? S_SCROLL : S_RESP;
                            end
                            tcw_pkg::KindClear: begin
                                r_row   <= '0;
                                r_col   <= '0;
                                r_state <= S_CLEAR;
                            end
                            tcw_pkg::KindRead: begin
                                r_rd_sel <= addr_ok;
                                r_state  <= S_RESP;
                            end
                            default: begin
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    if (r_idx == IW'(Cells - 1)) begin
                        r_state <= S_RESP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SCROLL: begin
                    if (r_idx == IW'(Cells)) begin
                        // last write-back lands this cycle
                        r_idx     <= '0;
                        r_scrolls <= r_scrolls - 2'd1;
                        if (r_scrolls == 2'd1) begin
                            r_state <= r_do_put ? S_PUT : S_RESP;
                        end
                    end else begin
                        r_idx     <= r_idx + 1'b1;
                        r_wr_pend <= 1'b1;
                        r_wr_addr <= r_idx[AW-1:0];
                        r_wr_src  <= r_idx < IW'(Cells - COLUMNS);
                    end
                end
                S_PUT: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    assign o_req_ready             = (r_state == S_IDLE);
    assign o_res_valid             = (r_state == S_RESP);
    assign o_res.read_data         = r_rd_sel ? i_mem_rdata : '0;
    assign o_res.cursor_row        = RowOutW'(r_row);
    assign o_res.cursor_column     = ColOutW'(r_col);

    `TCW_ASSERT(a_row_bound, r_row <= RW'(ROWS), "cursor row beyond scroll-pending row")
    `TCW_ASSERT(a_col_bound, r_col <= CW'(COLUMNS), "cursor column beyond wrap column")
    `TCW_ASSERT(a_wb_in_scroll, r_wr_pend |-> (r_state == S_SCROLL), "write-back outside scroll")
    `TCW_ASSERT(a_accept_busy, accept |=> (r_state != S_IDLE), "accepted beat left sequencer idle")
    `TCW_ASSERT_RST(a_reset_init, !i_rst_n |=> (r_state == S_INIT && r_idx == '0), "no init pass")

endmodule

// ----- rtl/text_console_writer_top.sv -----
// Text console writer: a COLUMNS x ROWS screen of 16-bit cells (attribute in
// the high byte, character in the low byte) plus a cursor.
// Input channel (i_in_valid/o_in_ready, i_in): one beat per command: write a
// character (code 10 is a newline), clear the screen, or read one cell.
// Output channel (o_out_valid/i_out_ready, o_out): one beat per command with
// the read data (0 unless a valid read) and the cursor after the command.
// Config: i_cfg_we/i_cfg_data set the attribute byte; write only while idle.
// Result path: the controller enters its result state, then the beat is
// registered in the output register. A new command is taken only while the
// controller is idle, after the last result has moved on. Each scroll is one
// pass over the screen memory; a character written on a pending wrap at the
// bottom can need two scrolls. A clear is one pass over the screen memory.
// Reset: the cursor returns to 0,0, the attribute to 7, and a fill pass
// over the screen memory writes blank cells; o_in_ready stays low.
// Stall: a result waits in the output register; the next command is still
// taken and runs, then holds until that register frees up.
module text_console_writer_top #(
    parameter int COLUMNS = tcw_pkg::DefColumns,
    parameter int ROWS    = tcw_pkg::DefRows
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  tcw_pkg::t_in_beat         i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tcw_pkg::t_out_beat        o_out,
    input  logic                      i_cfg_we,
    input  logic [tcw_pkg::AttrW-1:0] i_cfg_data
);

    localparam int Cells = COLUMNS * ROWS;
    localparam int AW    = $clog2(Cells);

    logic [tcw_pkg::AttrW-1:0] r_attr;
    logic                      r_out_valid;
    tcw_pkg::t_out_beat        r_out;

    logic                      res_valid;
    logic                      res_ready;
    tcw_pkg::t_out_beat        res;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [tcw_pkg::CellW-1:0] mem_wdata;
    logic                      mem_re;
    logic [AW-1:0]             mem_raddr;
    logic [tcw_pkg::CellW-1:0] mem_rdata;

    assign res_ready = !r_out_valid || i_out_ready;

    // Attribute register and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= tcw_pkg::ResetAttr;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_req       (i_in),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .i_attr      (r_attr),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CellW),
        .DEPTH (Cells)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
